>>> design/spd_pkg.sv
package spd_pkg;

    // Header constants
    localparam logic [31:0] MAGIC_WORD = 32'h50feeb1e;
    localparam logic [15:0] TYPE_LIMIT = 16'd4;
    localparam logic [15:0] WIN_LEN    = 16'd8;

    // Packet types
    localparam logic [1:0] TYPE_AUTH   = 2'd0;
    localparam logic [1:0] TYPE_DATA   = 2'd1;
    localparam logic [1:0] TYPE_WINDOW = 2'd2;

    // Authentication status
    localparam logic [1:0] ST_INIT   = 2'd0;
    localparam logic [1:0] ST_AUTHED = 2'd1;
    localparam logic [1:0] ST_FAILED = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_AUTH_REQUIRED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECRET_LEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECRET_BASE   = 3'd2;

    // Result event kinds
    localparam logic [2:0] EV_PAYLOAD   = 3'd0;
    localparam logic [2:0] EV_WINDOW    = 3'd1;
    localparam logic [2:0] EV_AUTH_OK   = 3'd2;
    localparam logic [2:0] EV_AUTH_FAIL = 3'd3;
    localparam logic [2:0] EV_FATAL     = 3'd4;

    // Fatal error kinds
    localparam logic [1:0] ERR_MAGIC   = 2'd0;
    localparam logic [1:0] ERR_TYPE    = 2'd1;
    localparam logic [1:0] ERR_PREAUTH = 2'd2;
    localparam logic [1:0] ERR_PWLEN   = 2'd3;

    // Operations passed from front to back
    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_WIN   = 2'd1;
    localparam logic [1:0] OP_AUTH  = 2'd2;
    localparam logic [1:0] OP_FATAL = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic       ok;
        logic [1:0] err;
    } op_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [31:0] win_rows;
        logic [31:0] win_cols;
        logic [1:0]  error_kind;
    } result_t;

endpackage

>>> design/spd_fifo.sv
module spd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> design/spd_front.sv
module spd_front #(
    parameter int SECRET_BYTES       = 40,
    parameter int PASSWORD_BUF_BYTES = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           take,
    input  logic [7:0]                     in_byte,
    input  logic                           cfg_we,
    input  logic [spd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                    cfg_data,
    output logic                           op_valid,
    output spd_pkg::op_t                   op
);
    import spd_pkg::*;

    localparam int SECRET_REGS = (SECRET_BYTES + 7) / 8;
    localparam int RSEL_W      = (SECRET_REGS > 1) ? $clog2(SECRET_REGS) : 1;
    localparam int IDX_W       = $clog2(PASSWORD_BUF_BYTES);

    // Configuration
    logic        auth_required_reg;
    logic [5:0]  secret_len_reg;
    logic [63:0] secret_reg [SECRET_REGS];

    // Parser state
    logic [55:0]      hdr_shift_reg, hdr_shift_next;
    logic [2:0]       hdr_count_reg, hdr_count_next;
    logic [1:0]       pkt_type_reg, pkt_type_next;
    logic [15:0]      remaining_reg, remaining_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic             in_payload_reg, in_payload_next;
    logic             skip_reg, skip_next;
    logic             match_reg, match_next;
    logic [1:0]       auth_status_reg, auth_status_next;
    logic             halted_reg, halted_next;

    logic [63:0]       header;
    logic [31:0]       magic;
    logic [15:0]       ptype;
    logic [15:0]       plen;
    logic              preauth;
    logic              len_match;
    logic              pw_too_long;
    logic [15:0]       rem_dec;
    logic              last;
    logic [15:0]       sidx;
    logic [RSEL_W-1:0] sel_reg;
    logic              in_range;
    logic [63:0]       sec_word;
    logic [63:0]       sec_shift;
    logic              byte_match;

    // Decode the header as it completes
    assign header      = {hdr_shift_reg, in_byte};
    assign magic       = header[63:32];
    assign ptype       = header[31:16];
    assign plen        = header[15:0];
    assign preauth     = auth_required_reg && (auth_status_reg != ST_AUTHED);
    assign len_match   = (16'(secret_len_reg) == plen)
                         && (7'(secret_len_reg) <= 7'(SECRET_BYTES));
    assign pw_too_long = (32'(plen) >= 32'(PASSWORD_BUF_BYTES));
    assign rem_dec     = remaining_reg - 16'd1;
    assign last        = (rem_dec == 16'd0);

    // Look up the secret byte for the current password position
    assign sidx       = 16'(index_reg);
    assign sel_reg    = sidx[3 +: RSEL_W];
    assign in_range   = (32'(index_reg) < 32'(SECRET_BYTES));
    assign sec_word   = in_range ? secret_reg[sel_reg] : 64'd0;
    assign sec_shift  = sec_word >> {sidx[2:0], 3'b000};
    assign byte_match = match_reg && in_range && (sec_shift[7:0] == in_byte);

    // Classify each accepted byte
    always_comb
    begin
        hdr_shift_next   = hdr_shift_reg;
        hdr_count_next   = hdr_count_reg;
        pkt_type_next    = pkt_type_reg;
        remaining_next   = remaining_reg;
        index_next       = index_reg;
        in_payload_next  = in_payload_reg;
        skip_next        = skip_reg;
        match_next       = match_reg;
        auth_status_next = auth_status_reg;
        halted_next      = halted_reg;
        op_valid         = 1'b0;
        op               = '0;

        if (take && !halted_reg)
        begin
            if (!in_payload_reg)
            begin
                if (hdr_count_reg != 3'd7)
                begin
                    hdr_count_next = hdr_count_reg + 3'd1;
                    hdr_shift_next = header[55:0];
                end
                else
                begin
                    hdr_count_next = '0;
                    if (magic != MAGIC_WORD)
                    begin
                        halted_next = 1'b1;
                        op_valid    = 1'b1;
                        op.kind     = OP_FATAL;
                        op.err      = ERR_MAGIC;
                    end
                    else if (ptype >= TYPE_LIMIT)
                    begin
                        halted_next = 1'b1;
                        op_valid    = 1'b1;
                        op.kind     = OP_FATAL;
                        op.err      = ERR_TYPE;
                    end
                    else
                    begin
                        pkt_type_next  = ptype[1:0];
                        remaining_next = plen;
                        index_next     = '0;
                        if (preauth)
                        begin
                            if (ptype[1:0] != TYPE_AUTH)
                            begin
                                halted_next = 1'b1;
                                op_valid    = 1'b1;
                                op.kind     = OP_FATAL;
                                op.err      = ERR_PREAUTH;
                            end
                            else if (pw_too_long)
                            begin
                                halted_next = 1'b1;
                                op_valid    = 1'b1;
                                op.kind     = OP_FATAL;
                                op.err      = ERR_PWLEN;
                            end
                            else
                            begin
                                skip_next  = 1'b0;
                                match_next = len_match;
                                if (plen == 16'd0)
                                begin
                                    // Empty password: give the verdict now
                                    auth_status_next = len_match ? ST_AUTHED : ST_FAILED;
                                    op_valid         = 1'b1;
                                    op.kind          = OP_AUTH;
                                    op.ok            = len_match;
                                end
                                else
                                begin
                                    in_payload_next = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            case (ptype[1:0])
                                TYPE_DATA:   skip_next = 1'b0;
                                TYPE_WINDOW: skip_next = (plen != WIN_LEN);
                                default:     skip_next = 1'b1;
                            endcase
                            match_next      = 1'b1;
                            in_payload_next = (plen != 16'd0);
                        end
                    end
                end
            end
            else
            begin
                remaining_next = rem_dec;
                index_next     = index_reg + 1'b1;
                if (last)
                begin
                    in_payload_next = 1'b0;
                end
                if (!skip_reg)
                begin
                    case (pkt_type_reg)
                        TYPE_AUTH:
                        begin
                            match_next = byte_match;
                            if (last)
                            begin
                                auth_status_next = byte_match ? ST_AUTHED : ST_FAILED;
                                op_valid         = 1'b1;
                                op.kind          = OP_AUTH;
                                op.ok            = byte_match;
                            end
                        end
                        TYPE_DATA:
                        begin
                            op_valid = 1'b1;
                            op.kind  = OP_DATA;
                            op.data  = in_byte;
                            op.last  = last;
                        end
                        TYPE_WINDOW:
                        begin
                            op_valid = 1'b1;
                            op.kind  = OP_WIN;
                            op.data  = in_byte;
                            op.last  = last;
                        end
                        default:
                        begin
                            op_valid = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_shift_reg   <= '0;
            hdr_count_reg   <= '0;
            pkt_type_reg    <= '0;
            remaining_reg   <= '0;
            index_reg       <= '0;
            in_payload_reg  <= 1'b0;
            skip_reg        <= 1'b0;
            match_reg       <= 1'b1;
            auth_status_reg <= ST_INIT;
            halted_reg      <= 1'b0;
        end
        else
        begin
            hdr_shift_reg   <= hdr_shift_next;
            hdr_count_reg   <= hdr_count_next;
            pkt_type_reg    <= pkt_type_next;
            remaining_reg   <= remaining_next;
            index_reg       <= index_next;
            in_payload_reg  <= in_payload_next;
            skip_reg        <= skip_next;
            match_reg       <= match_next;
            auth_status_reg <= auth_status_next;
            halted_reg      <= halted_next;
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auth_required_reg <= 1'b0;
            secret_len_reg    <= '0;
            for (int r = 0; r < SECRET_REGS; r++)
            begin
                secret_reg[r] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_AUTH_REQUIRED)
            begin
                auth_required_reg <= cfg_data[0];
            end
            if (cfg_index == REG_SECRET_LEN)
            begin
                secret_len_reg <= cfg_data[5:0];
            end
            for (int r = 0; r < SECRET_REGS; r++)
            begin
                if (cfg_index == CFG_IDX_W'(int'(REG_SECRET_BASE) + r))
                begin
                    secret_reg[r] <= cfg_data;
                end
            end
        end
    end

endmodule

>>> design/spd_back.sv
module spd_back (
    input  logic              clk,
    input  logic              op_valid,
    input  spd_pkg::op_t      op,
    output logic              op_pop,
    input  logic              res_full,
    output logic              res_push,
    output spd_pkg::result_t  res
);
    import spd_pkg::*;

    logic [55:0] accum_reg;
    logic [63:0] accum_shift;
    logic        take;

    assign take        = op_valid && !res_full;
    assign op_pop      = take;
    assign accum_shift = {accum_reg, op.data};

    // Build the result word for the waiting operation
    always_comb
    begin
        res      = '0;
        res_push = 1'b0;
        unique case (op.kind)
            OP_DATA:
            begin
                res.event_kind   = EV_PAYLOAD;
                res.payload_byte = op.data;
                res.payload_last = op.last;
                res_push         = take;
            end
            OP_WIN:
            begin
                res.event_kind = EV_WINDOW;
                res.win_rows   = accum_shift[63:32];
                res.win_cols   = accum_shift[31:0];
                res_push       = take && op.last;
            end
            OP_AUTH:
            begin
                res.event_kind = op.ok ? EV_AUTH_OK : EV_AUTH_FAIL;
                res_push       = take;
            end
            OP_FATAL:
            begin
                res.event_kind = EV_FATAL;
                res.error_kind = op.err;
                res_push       = take;
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    // Shift window bytes in; a window packet is exactly eight bytes long
    always_ff @(posedge clk)
    begin
        if (take && (op.kind == OP_WIN))
        begin
            accum_reg <= accum_shift[55:0];
        end
    end

endmodule

>>> design/session_packet_deframer.sv
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-------------------------------------
// input    | in        | push / full               | in_byte
// result   | out       | pop / empty               | event_kind, payload_byte, payload_last,
//          |           |                           | win_rows, win_cols, error_kind
// config   | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One byte is accepted per cycle while full is low. A result passes through the operation
// queue and then the result queue before it shows on the result ports.
// Reset is asynchronous and clears all control state at once; no sweep follows it.
// full rises when the two-entry operation queue holds two words, which can build up only
// while the two-entry result queue is full.
module session_packet_deframer #(
    parameter int SECRET_BYTES       = 40,
    parameter int PASSWORD_BUF_BYTES = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    in_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [2:0]                    event_kind,
    output logic [7:0]                    payload_byte,
    output logic                          payload_last,
    output logic [31:0]                   win_rows,
    output logic [31:0]                   win_cols,
    output logic [1:0]                    error_kind,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);
    import spd_pkg::*;

    localparam int OP_W  = $bits(op_t);
    localparam int RES_W = $bits(result_t);

    logic    take;
    logic    op_valid_in;
    op_t     op_in;
    logic    opq_full;
    logic    opq_empty;
    op_t     op_head;
    logic    op_pop;
    logic    res_push;
    logic    resq_full;
    result_t res_in;
    result_t res_head;

    assign cfg_ready = 1'b1;
    assign full      = opq_full;
    assign take      = push && !opq_full;

    // Parse bytes and emit operations
    spd_front #(
        .SECRET_BYTES       (SECRET_BYTES),
        .PASSWORD_BUF_BYTES (PASSWORD_BUF_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .in_byte   (in_byte),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_valid  (op_valid_in),
        .op        (op_in)
    );

    // Decouple parser from result stage
    spd_fifo #(
        .WIDTH (OP_W),
        .DEPTH (2)
    ) u_opq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (op_valid_in),
        .wr_data (op_in),
        .full    (opq_full),
        .pop     (op_pop),
        .rd_data (op_head),
        .empty   (opq_empty)
    );

    // Carry out operations
    spd_back u_back (
        .clk      (clk),
        .op_valid (!opq_empty),
        .op       (op_head),
        .op_pop   (op_pop),
        .res_full (resq_full),
        .res_push (res_push),
        .res      (res_in)
    );

    // Hold results until popped
    spd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (resq_full),
        .pop     (pop),
        .rd_data (res_head),
        .empty   (empty)
    );

    assign event_kind   = res_head.event_kind;
    assign payload_byte = res_head.payload_byte;
    assign payload_last = res_head.payload_last;
    assign win_rows     = res_head.win_rows;
    assign win_cols     = res_head.win_cols;
    assign error_kind   = res_head.error_kind;

endmodule

>>> tb/session_packet_deframer_checker.sv
module session_packet_deframer_checker #(
    parameter int SECRET_BYTES       = 40,
    parameter int PASSWORD_BUF_BYTES = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic [7:0]                    in_byte,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [2:0]                    event_kind,
    input  logic [7:0]                    payload_byte,
    input  logic                          payload_last,
    input  logic [31:0]                   win_rows,
    input  logic [31:0]                   win_cols,
    input  logic [1:0]                    error_kind,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    output int                            pending,
    output int                            fail_count,
    output int                            result_total
);
    timeunit 1ns;
    timeprecision 1ps;

    import spd_pkg::*;

    localparam int SECRET_REGS  = 5;
    localparam int REPORT_LIMIT = 40;

    // Configuration copy
    logic        auth_req;
    logic [5:0]  secret_len;
    logic [63:0] secret_word [SECRET_REGS];

    // Deframer state
    logic [63:0] hdr_shift;
    logic [3:0]  hdr_count;
    logic [1:0]  pkt_type;
    logic [15:0] remaining;
    logic [15:0] pay_index;
    logic        in_pay;
    logic        skip_pay;
    logic        pw_match;
    logic [1:0]  auth_state;
    logic [63:0] win_accum;
    logic        halted;

    result_t expected_events [$];
    int      errors;
    int      compared;

    function automatic logic [7:0] secret_at(input logic [15:0] k);
        if (k >= SECRET_BYTES)
            return 8'h00;
        return secret_word[k[5:3]][k[2:0]*8 +: 8];
    endfunction

    task automatic post_event(input logic [2:0] kind, input logic [7:0] b, input logic last,
                              input logic [31:0] rows, input logic [31:0] cols,
                              input logic [1:0] err);
        result_t ev;
        ev.event_kind   = kind;
        ev.payload_byte = b;
        ev.payload_last = last;
        ev.win_rows     = rows;
        ev.win_cols     = cols;
        ev.error_kind   = err;
        expected_events.push_back(ev);
    endtask

    task automatic raise_fatal(input logic [1:0] kind);
        halted = 1'b1;
        in_pay = 1'b0;
        post_event(EV_FATAL, 8'h00, 1'b0, 32'h0, 32'h0, kind);
    endtask

    task automatic give_verdict();
        in_pay     = 1'b0;
        auth_state = pw_match ? ST_AUTHED : ST_FAILED;
        post_event(pw_match ? EV_AUTH_OK : EV_AUTH_FAIL, 8'h00, 1'b0, 32'h0, 32'h0, 2'd0);
    endtask

    // Check magic and type, then set up the payload that follows
    task automatic decode_header();
        logic [31:0] magic;
        logic [15:0] ptype;
        logic [15:0] plen;
        logic        preauth;
        magic     = hdr_shift[63:32];
        ptype     = hdr_shift[31:16];
        plen      = hdr_shift[15:0];
        preauth   = auth_req && (auth_state != ST_AUTHED);
        hdr_count = 4'd0;
        if (magic != MAGIC_WORD)
            raise_fatal(ERR_MAGIC);
        else if (ptype >= TYPE_LIMIT)
            raise_fatal(ERR_TYPE);
        else
        begin
            pkt_type  = ptype[1:0];
            remaining = plen;
            pay_index = 16'd0;
            win_accum = 64'd0;
            if (preauth)
            begin
                if (pkt_type != TYPE_AUTH)
                    raise_fatal(ERR_PREAUTH);
                else if (plen >= PASSWORD_BUF_BYTES)
                    raise_fatal(ERR_PWLEN);
                else
                begin
                    skip_pay = 1'b0;
                    pw_match = (plen == secret_len) && (secret_len <= SECRET_BYTES);
                    if (plen == 16'd0)
                        give_verdict();
                    else
                        in_pay = 1'b1;
                end
            end
            else
            begin
                if (pkt_type == TYPE_DATA)
                    skip_pay = 1'b0;
                else if (pkt_type == TYPE_WINDOW)
                    skip_pay = (plen != WIN_LEN);
                else
                    skip_pay = 1'b1;
                pw_match = 1'b1;
                in_pay   = (plen != 16'd0);
            end
        end
    endtask

    // Advance the deframer by one input word
    task automatic deframe_byte(input logic [7:0] b);
        logic last;
        if (!halted)
        begin
            if (!in_pay)
            begin
                hdr_shift = {hdr_shift[55:0], b};
                hdr_count = hdr_count + 4'd1;
                if (hdr_count >= 4'd8)
                    decode_header();
            end
            else
            begin
                remaining = remaining - 16'd1;
                last      = (remaining == 16'd0);
                if (last)
                    in_pay = 1'b0;
                if (skip_pay)
                    pay_index = pay_index + 16'd1;
                else if (pkt_type == TYPE_AUTH)
                begin
                    if (pay_index >= SECRET_BYTES || secret_at(pay_index) != b)
                        pw_match = 1'b0;
                    pay_index = pay_index + 16'd1;
                    if (last)
                        give_verdict();
                end
                else
                begin
                    pay_index = pay_index + 16'd1;
                    if (pkt_type == TYPE_DATA)
                        post_event(EV_PAYLOAD, b, last, 32'h0, 32'h0, 2'd0);
                    else
                    begin
                        win_accum = {win_accum[55:0], b};
                        if (last)
                            post_event(EV_WINDOW, 8'h00, 1'b0, win_accum[63:32],
                                       win_accum[31:0], 2'd0);
                    end
                end
            end
        end
    endtask

    task automatic apply_config(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        if (idx == REG_AUTH_REQUIRED)
            auth_req = data[0];
        else if (idx == REG_SECRET_LEN)
            secret_len = data[5:0];
        else if (idx >= REG_SECRET_BASE && idx < REG_SECRET_BASE + SECRET_REGS)
            secret_word[idx - REG_SECRET_BASE] = data;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Compare the popped word with the oldest expected event
    task automatic check_result();
        result_t want;
        if (expected_events.size() == 0)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t ns: unexpected result, expected none, actual kind %0d byte %0h",
                         $time, event_kind, payload_byte);
        end
        else
        begin
            want = expected_events.pop_front();
            compared++;
            check_field("event_kind", want.event_kind, event_kind);
            check_field("payload_byte", want.payload_byte, payload_byte);
            check_field("payload_last", want.payload_last, payload_last);
            check_field("win_rows", want.win_rows, win_rows);
            check_field("win_cols", want.win_cols, win_cols);
            check_field("error_kind", want.error_kind, error_kind);
        end
    endtask

    // Track every handshake on the three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auth_req   = 1'b0;
            secret_len = 6'd0;
            for (int i = 0; i < SECRET_REGS; i++)
                secret_word[i] = 64'd0;
            hdr_shift  = 64'd0;
            hdr_count  = 4'd0;
            pkt_type   = 2'd0;
            remaining  = 16'd0;
            pay_index  = 16'd0;
            in_pay     = 1'b0;
            skip_pay   = 1'b0;
            pw_match   = 1'b1;
            auth_state = ST_INIT;
            win_accum  = 64'd0;
            halted     = 1'b0;
            expected_events.delete();
            errors     = 0;
            compared   = 0;
            pending      <= 0;
            fail_count   <= 0;
            result_total <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_config(cfg_index, cfg_data);
            if (pop && !empty)
                check_result();
            if (push && !full)
                deframe_byte(in_byte);
            pending      <= expected_events.size();
            fail_count   <= errors;
            result_total <= compared;
        end
    end

endmodule

>>> tb/session_packet_deframer_tb.sv
module session_packet_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spd_pkg::*;

    localparam int         SECRET_BYTES       = 40;
    localparam int         PASSWORD_BUF_BYTES = 128;
    localparam int         SECRET_REGS        = 5;
    localparam int         HOLD_CYCLES        = 150;
    localparam logic [1:0] TYPE_SIGNAL        = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic [7:0]           in_byte   = 8'h00;
    logic                 pop       = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data  = 64'd0;
    logic                 full;
    logic                 empty;
    logic [2:0]           event_kind;
    logic [7:0]           payload_byte;
    logic                 payload_last;
    logic [31:0]          win_rows;
    logic [31:0]          win_cols;
    logic [1:0]           error_kind;
    logic                 cfg_ready;
    int                   pending;
    int                   fail_count;
    int                   result_total;

    // Stimulus bookkeeping
    logic [7:0] body [$];
    logic [7:0] secret_mem [SECRET_BYTES];
    int         secret_size;
    int         bytes_sent;
    int         packets_sent;
    int         auth_tries;
    int         hold_token;
    bit         tx_quiet;

    session_packet_deframer #(
        .SECRET_BYTES      (SECRET_BYTES),
        .PASSWORD_BUF_BYTES(PASSWORD_BUF_BYTES)
    ) i_dut (
        .clk, .rst_n, .push, .full, .in_byte, .empty, .pop,
        .event_kind, .payload_byte, .payload_last, .win_rows, .win_cols, .error_kind,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    session_packet_deframer_checker #(
        .SECRET_BYTES      (SECRET_BYTES),
        .PASSWORD_BUF_BYTES(PASSWORD_BUF_BYTES)
    ) i_checker (
        .clk, .rst_n, .push, .full, .in_byte, .empty, .pop,
        .event_kind, .payload_byte, .payload_last, .win_rows, .win_cols, .error_kind,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .pending, .fail_count, .result_total
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    // Hold each input word until the block takes it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(39) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(18);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_byte <= b;
        do
            @(posedge clk);
        while (full);
        bytes_sent++;
    endtask

    // Send a header, then whatever sits in body
    task automatic send_packet(input logic [31:0] magic, input logic [15:0] ptype,
                               input logic [15:0] plen);
        logic [63:0] hdr;
        hdr = {magic, ptype, plen};
        for (int k = 7; k >= 0; k--)
            send_byte(hdr[k*8 +: 8]);
        for (int k = 0; k < body.size(); k++)
            send_byte(body[k]);
        packets_sent++;
    endtask

    task automatic fill_random(input int n);
        body.delete();
        repeat (n) body.push_back(8'($urandom));
    endtask

    // Stop input and wait until every expected event has been popped
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Leave valid high so back-to-back writes need no gap
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic end_config();
        cfg_valid <= 1'b0;
    endtask

    task automatic set_auth_required(input logic on);
        write_reg(REG_AUTH_REQUIRED, {32'($urandom), 31'($urandom), on});
    endtask

    // Pick new secret bytes and write length and all secret registers
    task automatic program_secret(input int len);
        int          style;
        logic [63:0] word;
        style = $urandom_range(5);
        for (int k = 0; k < SECRET_BYTES; k++)
        begin
            if (style == 0)
                secret_mem[k] = 8'h00;
            else if (style == 1)
                secret_mem[k] = 8'hff;
            else if ($urandom_range(7) == 0)
                secret_mem[k] = 8'h00;
            else
                secret_mem[k] = 8'($urandom);
        end
        secret_size = len;
        write_reg(REG_SECRET_LEN, {32'($urandom), 26'($urandom), 6'(len)});
        for (int w = 0; w < SECRET_REGS; w++)
        begin
            for (int k = 0; k < 8; k++)
                word[k*8 +: 8] = secret_mem[w*8 + k];
            write_reg(REG_SECRET_BASE + 3'(w), word);
        end
    endtask

    function automatic int pick_secret_len();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 0;
        if (r == 1)
            return SECRET_BYTES;
        if (r == 2)
            return $urandom_range(63, SECRET_BYTES + 1);
        return $urandom_range(SECRET_BYTES - 1, 1);
    endfunction

    // Build a password: the secret itself, or one that must fail
    task automatic send_auth(input bit good);
        int len;
        int pos;
        bit flip;
        flip = !good && secret_size >= 1 && secret_size <= SECRET_BYTES && $urandom_range(1);
        if (good || flip)
            len = secret_size;
        else
        begin
            do
                len = ($urandom_range(7) == 0) ? $urandom_range(PASSWORD_BUF_BYTES - 1)
                                               : $urandom_range(48);
            while (len == secret_size);
        end
        body.delete();
        for (int k = 0; k < len; k++)
            body.push_back(k < SECRET_BYTES ? secret_mem[k] : 8'($urandom));
        if (flip)
        begin
            pos       = $urandom_range(len - 1);
            body[pos] = body[pos] ^ 8'($urandom_range(255, 1));
        end
        else if (!good && $urandom_range(3) == 0)
            fill_random(len);
        auth_tries++;
        send_packet(MAGIC_WORD, {14'd0, TYPE_AUTH}, 16'(len));
    endtask

    // One well-formed packet of any type, as seen once authenticated
    task automatic send_random_packet();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 50)
        begin
            if ($urandom_range(9) == 0)
                len = 0;
            else if ($urandom_range(19) == 0)
                len = $urandom_range(300, 100);
            else
                len = $urandom_range(12, 1);
            fill_random(len);
            send_packet(MAGIC_WORD, {14'd0, TYPE_DATA}, 16'(len));
        end
        else if (r < 70)
        begin
            fill_random(8);
            if ($urandom_range(7) == 0)
                foreach (body[k]) body[k] = $urandom_range(1) ? 8'hff : 8'h00;
            send_packet(MAGIC_WORD, {14'd0, TYPE_WINDOW}, 16'd8);
        end
        else if (r < 78)
        begin
            do
                len = $urandom_range(20);
            while (len == 8);
            fill_random(len);
            send_packet(MAGIC_WORD, {14'd0, TYPE_WINDOW}, 16'(len));
        end
        else if (r < 88)
        begin
            len = $urandom_range(20);
            fill_random(len);
            send_packet(MAGIC_WORD, {14'd0, TYPE_SIGNAL}, 16'(len));
        end
        else
        begin
            len = $urandom_range(SECRET_BYTES);
            fill_random(len);
            send_packet(MAGIC_WORD, {14'd0, TYPE_AUTH}, 16'(len));
        end
    endtask

    // Drop results at random rates, with one long hold-off on request
    initial
    begin : result_sink
        int gap;
        int hold_seen;
        bit rx_quiet;
        hold_seen = 0;
        rx_quiet  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(29) == 0)
                rx_quiet = !rx_quiet;
            gap = rx_quiet ? 0 : $urandom_range(18);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                gap       = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
        end
    end

    initial
    begin : stimulus
        bit          authenticate;
        int          r2_target;
        int          attempts;
        int          fatal_kind;
        logic [31:0] magic;
        logic [15:0] ptype;
        logic [15:0] plen;
        bytes_sent   = 0;
        packets_sent = 0;
        auth_tries   = 0;
        hold_token   = 0;
        tx_quiet     = 1'b0;
        secret_size  = 0;
        authenticate = $urandom_range(1);
        r2_target    = authenticate ? 1250 : 1650;

        // Reset
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Touch every register, the unused index too
        set_auth_required(1'b0);
        program_secret(SECRET_BYTES);
        write_reg(REG_SECRET_BASE + 3'(SECRET_REGS), {32'($urandom), 32'($urandom)});
        end_config();

        // Directed: no authentication needed, all packet shapes
        body = '{8'h00};
        send_packet(MAGIC_WORD, {14'd0, TYPE_DATA}, 16'd1);
        body = '{8'hff, 8'hff};
        send_packet(MAGIC_WORD, {14'd0, TYPE_DATA}, 16'd2);
        body.delete();
        send_packet(MAGIC_WORD, {14'd0, TYPE_DATA}, 16'd0);
        body = '{8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00};
        send_packet(MAGIC_WORD, {14'd0, TYPE_WINDOW}, 16'd8);
        body.delete();
        send_packet(MAGIC_WORD, {14'd0, TYPE_WINDOW}, 16'd0);
        fill_random(3);
        send_packet(MAGIC_WORD, {14'd0, TYPE_WINDOW}, 16'd3);
        fill_random(2);
        send_packet(MAGIC_WORD, {14'd0, TYPE_SIGNAL}, 16'd2);
        fill_random(3);
        send_packet(MAGIC_WORD, {14'd0, TYPE_AUTH}, 16'd3);

        // Back up the result side so the input stalls
        hold_token++;
        fill_random(60);
        send_packet(MAGIC_WORD, {14'd0, TYPE_DATA}, 16'd60);
        drain();

        // Random traffic with authentication off
        while (bytes_sent < 800)
        begin
            if (packets_sent % 30 == 29)
            begin
                drain();
                set_auth_required(1'b0);
                program_secret(pick_secret_len());
                end_config();
            end
            send_random_packet();
        end
        drain();

        // Directed: authentication on, failing passwords
        set_auth_required(1'b1);
        program_secret(SECRET_BYTES);
        end_config();
        body.delete();
        auth_tries++;
        send_packet(MAGIC_WORD, {14'd0, TYPE_AUTH}, 16'd0);
        send_auth(1'b0);
        send_auth(1'b0);
        drain();
        program_secret(63);
        end_config();
        send_auth(1'b0);

        // Random failing attempts, secret changed now and then
        attempts = 0;
        while (bytes_sent < r2_target)
        begin
            if (attempts % 8 == 7)
            begin
                drain();
                program_secret(pick_secret_len());
                end_config();
            end
            send_auth(1'b0);
            attempts++;
        end

        if (authenticate)
        begin
            drain();
            case ($urandom_range(2))
                0:       program_secret(0);
                1:       program_secret(SECRET_BYTES);
                default: program_secret($urandom_range(SECRET_BYTES - 1, 1));
            endcase
            end_config();
            send_auth(1'b1);

            // Random traffic once authenticated
            while (bytes_sent < 1650)
            begin
                if (packets_sent % 30 == 29)
                begin
                    drain();
                    set_auth_required(1'(($urandom_range(1))));
                    end_config();
                end
                send_random_packet();
            end
            fatal_kind = $urandom_range(ERR_TYPE, ERR_MAGIC);
        end
        else
            fatal_kind = $urandom_range(ERR_PWLEN, ERR_MAGIC);

        // Finish on a fatal header, then junk the block must drop
        magic = MAGIC_WORD;
        ptype = 16'($urandom);
        plen  = 16'($urandom);
        case (2'(fatal_kind))
            ERR_MAGIC: magic = MAGIC_WORD ^ (32'h1 << $urandom_range(31));
            ERR_TYPE:  ptype = $urandom_range(3) == 0 ? 16'hffff : 16'($urandom_range(65535, 4));
            ERR_PREAUTH: ptype = {14'd0, 2'($urandom_range(TYPE_SIGNAL, TYPE_DATA))};
            default:
            begin
                ptype = {14'd0, TYPE_AUTH};
                plen  = $urandom_range(1) ? 16'(PASSWORD_BUF_BYTES)
                                          : 16'($urandom_range(65535, PASSWORD_BUF_BYTES));
            end
        endcase
        fill_random(20);
        send_packet(magic, ptype, plen);
        drain();
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes in %0d packets, %0d password attempts, %0d results checked.",
                 bytes_sent, packets_sent, auth_tries, result_total);
        $display("Authentication %s; stream closed by fatal error kind %0d.",
                 authenticate ? "granted" : "never granted", fatal_kind);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
